[hw/rtl/chm_pkg.sv]
package chm_pkg;

	// Fixed widths of the channel payloads and the configuration register.
	localparam int KIND_W   = 2;
	localparam int KEY_W    = 32;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 4;

	// Bucket count after reset.
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd7;

	// Default geometry of the table.
	localparam int DEF_BUCKETS    = 8;
	localparam int DEF_SLOTS      = 4;
	localparam int DEF_KEY_BITS   = 32;
	localparam int DEF_VALUE_BITS = 32;

	// The remainder unit retires this many key bits per cycle.
	localparam int DIGIT_BITS = 4;
	// The divisor is as wide as the configuration register.
	localparam int DIV_W = CFG_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_SEARCH = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_DISPATCH,
		S_READ,
		S_CMP,
		S_SHIFT,
		S_MOVE,
		S_FINISH
	} state_t;

	// Request to the remainder unit.
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] divisor;
	} mod_req_t;

	// Result of the remainder unit; rem is valid while busy is low.
	typedef struct packed {
		logic             busy;
		logic [DIV_W-1:0] rem;
	} mod_res_t;

endpackage

[hw/rtl/chm_req_if.sv]
interface chm_req_if;
	import chm_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [KEY_W-1:0]   key;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output kind, output key, output value, input ready);
	modport sink (input valid, input kind, input key, input value, output ready);

endinterface

[hw/rtl/chm_rsp_if.sv]
interface chm_rsp_if;
	import chm_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [VALUE_W-1:0]  found_value;

	modport source (output valid, output status, output found_value, input ready);
	modport sink (input valid, input status, input found_value, output ready);

endinterface

[hw/rtl/chained_hash_map.sv]
// Key-to-value hash map with separate chaining.
// Requests arrive on req (kind, key, value) and each yields exactly one beat on
// rsp (status, found_value). The bucket is the key modulo the bucket count,
// which is to be written through cfg_we/cfg_wdata only while the block is
// idle, a rule that the block itself does not enforce; zero counts as one and
// values above BUCKETS saturate. An item is taken only in the idle state. The
// iterative remainder unit then takes the bucket four key bits at a time,
// followed by a dispatch state, a read and a compare state per slot compared
// through the slot memory, a shift and a move state per later entry moved down
// and a closing shift on a delete, and a finishing state that loads the
// response register. A new request is taken only once the item in hand has
// reached the response register.
// The response register holds a finished beat while the receiver stalls; the
// next request is accepted meanwhile and waits at completion until that beat
// has gone.
// Reset clears every bucket fill count and sets the bucket count to 7; slot
// contents are not cleared and are never used before they are written.
module chained_hash_map #(
	parameter int BUCKETS    = chm_pkg::DEF_BUCKETS,
	parameter int SLOTS      = chm_pkg::DEF_SLOTS,
	parameter int KEY_BITS   = chm_pkg::DEF_KEY_BITS,
	parameter int VALUE_BITS = chm_pkg::DEF_VALUE_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	chm_req_if.sink                   req,
	chm_rsp_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic [chm_pkg::CFG_W-1:0] cfg_wdata
);
	import chm_pkg::*;

	localparam int KW     = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int VW     = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
	localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int FILL_W = $clog2(SLOTS + 1);
	localparam int ADDR_W = BKT_W + SLOT_W;
	localparam int NB     = 1 << BKT_W;
	localparam int SAT    = (BUCKETS < 15) ? BUCKETS : 15;

	state_t              state_q, state_d;
	logic [CFG_W-1:0]    bucket_count_q;
	logic [DIV_W-1:0]    divisor;
	logic [DIV_W-1:0]    divisor_q;
	logic [KIND_W-1:0]   kind_q;
	logic [KW-1:0]       key_q;
	logic [VW-1:0]       val_q;
	logic [BKT_W-1:0]    bucket_q;
	logic [FILL_W-1:0]   fill_q [NB];
	logic [FILL_W-1:0]   fill_cur_q;
	logic [FILL_W-1:0]   fill_now;
	logic [FILL_W-1:0]   idx_q;
	logic [FILL_W-1:0]   idx_inc;
	status_t             status_q;
	logic [VW-1:0]       found_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [VW-1:0]       out_found_q;
	logic                accept;
	logic                out_load;

	mod_req_t            mod_req;
	mod_res_t            mod_res;

	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [KW-1:0]       mem_wkey;
	logic [VW-1:0]       mem_wdata;
	logic [ADDR_W-1:0]   mem_raddr;
	logic [KW-1:0]       rd_key;
	logic [VW-1:0]       rd_data;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= CFG_RESET;
		end else if (cfg_we) begin
			bucket_count_q <= cfg_wdata;
		end
	end

	// Divisor in use: zero counts as one, large counts saturate.
	always_comb begin
		if (bucket_count_q == '0) begin
			divisor = DIV_W'(1);
		end else if (bucket_count_q > CFG_W'(SAT)) begin
			divisor = DIV_W'(SAT);
		end else begin
			divisor = bucket_count_q;
		end
	end

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_load  = (state_q == S_FINISH) && (!out_valid_q || rsp.ready);
	assign fill_now  = fill_q[bucket_q];
	assign idx_inc   = idx_q + 1'b1;

	assign mod_req.start   = accept;
	assign mod_req.divisor = divisor;

	chm_mod_unit #(
		.KW (KW)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.key    (req.key[KW-1:0]),
		.res    (mod_res)
	);

	chm_slot_mem #(
		.ADDR_W (ADDR_W),
		.KW     (KW),
		.VW     (VW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wkey  (mem_wkey),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rkey  (rd_key),
		.rdata (rd_data)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and slot memory control.
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = {bucket_q, fill_now[SLOT_W-1:0]};
		mem_wkey  = key_q;
		mem_wdata = val_q;
		mem_raddr = {bucket_q, idx_q[SLOT_W-1:0]};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				if (!mod_res.busy) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_FINISH;
				if (kind_q == KIND_INSERT) begin
					mem_we = (fill_now != FILL_W'(SLOTS));
				end else if ((kind_q == KIND_DELETE || kind_q == KIND_SEARCH)
						&& fill_now != '0) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (rd_key == key_q) begin
					state_d = (kind_q == KIND_SEARCH) ? S_FINISH : S_SHIFT;
				end else if (idx_inc == fill_cur_q) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_READ;
				end
			end
			S_SHIFT: begin
				mem_raddr = {bucket_q, idx_inc[SLOT_W-1:0]};
				state_d   = (idx_inc < fill_cur_q) ? S_MOVE : S_FINISH;
			end
			S_MOVE: begin
				mem_we    = 1'b1;
				mem_waddr = {bucket_q, idx_q[SLOT_W-1:0]};
				mem_wkey  = rd_key;
				mem_wdata = rd_data;
				state_d   = S_SHIFT;
			end
			S_FINISH: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Per-item working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_q    <= req.kind;
					key_q     <= req.key[KW-1:0];
					val_q     <= req.value[VW-1:0];
					divisor_q <= divisor;
				end
			end
			S_HASH: begin
				bucket_q <= BKT_W'(mod_res.rem);
			end
			S_DISPATCH: begin
				found_q    <= '0;
				fill_cur_q <= fill_now;
				idx_q      <= '0;
				status_q   <= STAT_OK;
				if (kind_q == KIND_INSERT) begin
					if (fill_now == FILL_W'(SLOTS)) begin
						status_q <= STAT_FULL;
					end
				end else if ((kind_q == KIND_DELETE || kind_q == KIND_SEARCH)
						&& fill_now == '0) begin
					status_q <= STAT_MISS;
				end
			end
			S_CMP: begin
				if (rd_key == key_q) begin
					if (kind_q == KIND_SEARCH) begin
						found_q <= rd_data;
					end
				end else if (idx_inc == fill_cur_q) begin
					status_q <= STAT_MISS;
				end else begin
					idx_q <= idx_inc;
				end
			end
			S_MOVE: begin
				idx_q <= idx_inc;
			end
			default: begin
			end
		endcase
	end

	// Bucket fill counts: grow on a stored insert, shrink when a delete that found its key ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NB; b++) begin
				fill_q[b] <= '0;
			end
		end else if (state_q == S_DISPATCH && kind_q == KIND_INSERT
				&& fill_now != FILL_W'(SLOTS)) begin
			fill_q[bucket_q] <= fill_now + 1'b1;
		end else if (state_q == S_SHIFT && !(idx_inc < fill_cur_q)) begin
			fill_q[bucket_q] <= fill_cur_q - 1'b1;
		end
	end

	// Response register: holds a beat until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			out_found_q  <= found_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found_value = VALUE_W'(out_found_q);

	// The remainder unit is idle whenever a new item can be taken.
	a_mod_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !mod_res.busy)
		else $error("remainder unit busy while idle");

	// The bucket index is always below the divisor it was taken with.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DISPATCH |-> mod_res.rem < divisor_q)
		else $error("bucket remainder out of range");

	// The fill of the bucket in hand never exceeds the slot count.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DISPATCH |-> fill_now <= FILL_W'(SLOTS))
		else $error("bucket fill exceeds slot count");

	// A completed item always shows up on the response register.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && state_q == S_IDLE)
		else $error("finished item not presented");

endmodule

[hw/rtl/chm_mod_unit.sv]
module chm_mod_unit #(
	parameter int KW = chm_pkg::KEY_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  chm_pkg::mod_req_t req,
	input  logic [KW-1:0]     key,
	output chm_pkg::mod_res_t res
);
	import chm_pkg::*;

	localparam int NSTEP = (KW + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int PAD_W = NSTEP * DIGIT_BITS;
	localparam int CNT_W = $clog2(NSTEP + 1);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PAD_W-1:0]   key_sr_q;
	logic [DIV_W-1:0]   div_q;
	logic [DIV_W-1:0]   rem_q;
	logic [DIV_W-1:0]   rem_next;

	// One digit of restoring division: shift in each of its key bits, subtracting the divisor if it fits.
	always_comb begin
		logic [DIV_W:0]   part;
		logic [DIV_W-1:0] r;
		r = rem_q;
		for (int j = 0; j < DIGIT_BITS; j++) begin
			part = {r, key_sr_q[PAD_W-1-j]};
			if (part >= {1'b0, div_q}) begin
				part = part - {1'b0, div_q};
			end
			r = part[DIV_W-1:0];
		end
		rem_next = r;
	end

	// Control of the digit loop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NSTEP);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Key shift register, divisor and partial remainder.
	always_ff @(posedge clk) begin
		if (req.start) begin
			key_sr_q <= PAD_W'(key);
			div_q    <= req.divisor;
			rem_q    <= '0;
		end else if (busy_q) begin
			key_sr_q <= key_sr_q << DIGIT_BITS;
			rem_q    <= rem_next;
		end
	end

	assign res.busy = busy_q;
	assign res.rem  = rem_q;

endmodule

[hw/rtl/chm_slot_mem.sv]
module chm_slot_mem #(
	parameter int ADDR_W = 5,
	parameter int KW     = chm_pkg::KEY_W,
	parameter int VW     = chm_pkg::VALUE_W
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [KW-1:0]     wkey,
	input  logic [VW-1:0]     wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [KW-1:0]     rkey,
	output logic [VW-1:0]     rdata
);
	localparam int DEPTH = 1 << ADDR_W;

	logic [KW-1:0] key_mem [DEPTH];
	logic [VW-1:0] data_mem [DEPTH];

	// One write port.
	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr]  <= wkey;
			data_mem[waddr] <= wdata;
		end
	end

	// One read port with registered data.
	always_ff @(posedge clk) begin
		rkey  <= key_mem[raddr];
		rdata <= data_mem[raddr];
	end

endmodule
